FILE: rtl/mep_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mep_pkg: shared types and constants of the Mandelbrot escape pixel block
// Field widths, configuration register codes, reset values and the queue
// status type shared by the front, the queue and the iteration engine.
// ----------------------------------------------------------------------------
package mep_pkg;

	localparam int COUNT_BITS     = 10;
	localparam int GREEN_BITS     = 8;
	localparam int INDEX_BITS     = 24;
	localparam int WIDTH_BITS     = 13;
	localparam int MAX_ITER_BITS  = 11;
	localparam int CFG_INDEX_BITS = 3;
	localparam int GREEN_MAX      = 255;
	localparam int GREEN_SCALE    = 3;
	localparam int MAG_LIMIT      = 4;
	localparam int PRODUCT_BITS   = 64;
	localparam int QUEUE_DEPTH    = 2;

	localparam longint X_START_RESET  = -536870912;
	localparam longint X_STEP_RESET   = 895779;
	localparam longint Y_START_RESET  = 268435456;
	localparam longint Y_STEP_RESET   = -896276;
	localparam longint WIDTH_RESET    = 900;
	localparam longint MAX_ITER_RESET = 256;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_X_START        = 3'd0,
		CFG_X_STEP         = 3'd1,
		CFG_Y_START        = 3'd2,
		CFG_Y_STEP         = 3'd3,
		CFG_IMAGE_WIDTH    = 3'd4,
		CFG_MAX_ITERATIONS = 3'd5
	} mep_cfg_index_t;

	typedef struct packed {
		logic full;
		logic empty;
	} mep_queue_status_t;

endpackage

FILE: rtl/mep_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mep_stream_if: pixel and result channels
// Valid/ready channels carrying a pixel position in and one escape result out.
// ----------------------------------------------------------------------------
interface mep_pixel_if #(
	parameter int POS_BITS = 12
);
	logic                valid;
	logic                ready;
	logic [POS_BITS-1:0] pixel_col;
	logic [POS_BITS-1:0] pixel_row;

	modport source(output valid, output pixel_col, output pixel_row, input ready);
	modport sink(input valid, input pixel_col, input pixel_row, output ready);
endinterface

interface mep_result_if;
	import mep_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [COUNT_BITS-1:0] escape_count;
	logic [GREEN_BITS-1:0] green_level;
	logic [INDEX_BITS-1:0] buffer_index;

	modport source(output valid, output escape_count, output green_level,
		output buffer_index, input ready);
	modport sink(input valid, input escape_count, input green_level,
		input buffer_index, output ready);
endinterface

FILE: rtl/mep_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mep_front: pixel intake and point mapping
// Two-stage pipeline that maps a pixel position to the saturated complex
// point c and the linear buffer index, then pushes both into the queue.
// ----------------------------------------------------------------------------
module mep_front #(
	parameter int COORD_BITS = 32,
	parameter int POS_BITS   = 12
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic signed [COORD_BITS-1:0]                 x_start,
	input  logic signed [COORD_BITS-1:0]                 x_step,
	input  logic signed [COORD_BITS-1:0]                 y_start,
	input  logic signed [COORD_BITS-1:0]                 y_step,
	input  logic [mep_pkg::WIDTH_BITS-1:0]               image_width,
	mep_pixel_if.sink                                    pixel_in,
	input  mep_pkg::mep_queue_status_t                   q_status,
	output logic                                         push,
	output logic [2*COORD_BITS+mep_pkg::INDEX_BITS-1:0]  push_data
);
	import mep_pkg::*;

	localparam int PROD_BITS = POS_BITS + 1 + COORD_BITS;
	localparam int SUM_BITS  = PROD_BITS + 1;
	localparam int RM_BITS   = POS_BITS + WIDTH_BITS;
	localparam int IDX_BITS  = (RM_BITS + 1 > INDEX_BITS) ? RM_BITS + 1 : INDEX_BITS;

	function automatic logic signed [COORD_BITS-1:0] sat_coord(
		input logic signed [SUM_BITS-1:0] v
	);
		logic [SUM_BITS-COORD_BITS:0] top;
		top = v[SUM_BITS-1:COORD_BITS-1];
		if ((&top) || !(|top))
			return v[COORD_BITS-1:0];
		else if (v[SUM_BITS-1])
			return {1'b1, {(COORD_BITS-1){1'b0}}};
		else
			return {1'b0, {(COORD_BITS-1){1'b1}}};
	endfunction

	logic                         run_q;
	logic                         advance;
	logic                         s1_valid;
	logic                         s2_valid;
	logic signed [PROD_BITS-1:0]  xprod_s1;
	logic signed [PROD_BITS-1:0]  yprod_s1;
	logic [RM_BITS-1:0]           rowmul_s1;
	logic [POS_BITS-1:0]          col_s1;
	logic signed [COORD_BITS-1:0] cr_s2;
	logic signed [COORD_BITS-1:0] ci_s2;
	logic [INDEX_BITS-1:0]        idx_s2;

	assign advance        = !s2_valid || !q_status.full;
	assign pixel_in.ready = advance && run_q;
	assign push           = s2_valid && !q_status.full;
	assign push_data      = {cr_s2, ci_s2, idx_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q    <= 1'b0;
			s1_valid <= 1'b0;
			s2_valid <= 1'b0;
		end else begin
			run_q <= 1'b1;
			if (advance) begin
				s1_valid <= pixel_in.valid && run_q;
				s2_valid <= s1_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			xprod_s1  <= PROD_BITS'(signed'({1'b0, pixel_in.pixel_col})) * PROD_BITS'(x_step);
			yprod_s1  <= PROD_BITS'(signed'({1'b0, pixel_in.pixel_row})) * PROD_BITS'(y_step);
			rowmul_s1 <= RM_BITS'(pixel_in.pixel_row) * RM_BITS'(image_width);
			col_s1    <= pixel_in.pixel_col;
			cr_s2     <= sat_coord(SUM_BITS'(xprod_s1) + SUM_BITS'(x_start));
			ci_s2     <= sat_coord(SUM_BITS'(yprod_s1) + SUM_BITS'(y_start));
			idx_s2    <= INDEX_BITS'(IDX_BITS'(rowmul_s1) + IDX_BITS'(col_s1));
		end
	end

endmodule

FILE: rtl/mep_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mep_queue: small register FIFO between front and iteration engine
// Holds mapped points so that intake and iteration stall independently.
// ----------------------------------------------------------------------------
module mep_queue #(
	parameter int WIDTH = 88,
	parameter int DEPTH = 2
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [WIDTH-1:0]           push_data,
	input  logic                       pop,
	output logic [WIDTH-1:0]           pop_data,
	output mep_pkg::mep_queue_status_t status
);
	import mep_pkg::*;

	localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_BITS = $clog2(DEPTH + 1);

	logic [WIDTH-1:0]    entries_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;
	logic                push_ok;
	logic                pop_ok;

	assign status.full  = (count_q == CNT_BITS'(DEPTH));
	assign status.empty = (count_q == '0);
	assign push_ok      = push && !status.full;
	assign pop_ok       = pop && !status.empty;
	assign pop_data     = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_ok)
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_BITS'(1);
			if (pop_ok)
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_BITS'(1);
			case ({push_ok, pop_ok})
				2'b10:   count_q <= count_q + CNT_BITS'(1);
				2'b01:   count_q <= count_q - CNT_BITS'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push_ok)
			entries_q[wr_ptr_q] <= push_data;
	end

endmodule

FILE: rtl/mep_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mep_back: escape-time iteration engine
// Iterates z = z^2 + c on one point at a time, each iteration a multiply
// step and then an add/test/saturate step, and holds the result in an output
// register until the receiver takes it.
// ----------------------------------------------------------------------------
module mep_back #(
	parameter int ITER_LIMIT = 1024,
	parameter int COORD_BITS = 32,
	parameter int FRAC_BITS  = 28
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic [mep_pkg::MAX_ITER_BITS-1:0]            max_iterations,
	input  mep_pkg::mep_queue_status_t                   q_status,
	output logic                                         pop,
	input  logic [2*COORD_BITS+mep_pkg::INDEX_BITS-1:0]  pop_data,
	mep_result_if.source                                 result_out
);
	import mep_pkg::*;

	localparam int ENTRY_BITS = 2 * COORD_BITS + INDEX_BITS;
	localparam int CNT_BITS   = $clog2(ITER_LIMIT + 1);
	localparam int GRAW_BITS  = (CNT_BITS + 2 > GREEN_BITS + 1) ? CNT_BITS + 2 : GREEN_BITS + 1;
	localparam logic signed [PRODUCT_BITS-1:0] FOUR =
		PRODUCT_BITS'(MAG_LIMIT) <<< FRAC_BITS;
	localparam logic signed [PRODUCT_BITS-1:0] COORD_MAX =
		(PRODUCT_BITS'(1) <<< (COORD_BITS - 1)) - PRODUCT_BITS'(1);
	localparam logic signed [PRODUCT_BITS-1:0] COORD_MIN = -COORD_MAX - PRODUCT_BITS'(1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_UPD,
		ST_FIN
	} state_t;

	function automatic logic signed [COORD_BITS-1:0] sat_coord(
		input logic signed [PRODUCT_BITS-1:0] v
	);
		if (v > COORD_MAX)
			return COORD_BITS'(COORD_MAX);
		else if (v < COORD_MIN)
			return COORD_BITS'(COORD_MIN);
		else
			return COORD_BITS'(v);
	endfunction

	state_t                         state_q;
	logic                           res_valid_q;
	logic [COUNT_BITS-1:0]          res_count_q;
	logic [GREEN_BITS-1:0]          res_green_q;
	logic [INDEX_BITS-1:0]          res_index_q;

	logic signed [COORD_BITS-1:0]   cr_q;
	logic signed [COORD_BITS-1:0]   ci_q;
	logic signed [COORD_BITS-1:0]   zr_q;
	logic signed [COORD_BITS-1:0]   zi_q;
	logic [INDEX_BITS-1:0]          idx_q;
	logic [CNT_BITS-1:0]            n_q;
	logic [CNT_BITS-1:0]            lim_q;
	logic [CNT_BITS-1:0]            count_q;
	logic signed [PRODUCT_BITS-1:0] prr_q;
	logic signed [PRODUCT_BITS-1:0] pii_q;
	logic signed [PRODUCT_BITS-1:0] pri_q;

	logic [CNT_BITS-1:0]            lim_next;
	logic [CNT_BITS-1:0]            n_next;
	logic signed [PRODUCT_BITS-1:0] rr;
	logic signed [PRODUCT_BITS-1:0] ii;
	logic signed [PRODUCT_BITS-1:0] ri;
	logic                           escaped;
	logic [GRAW_BITS-1:0]           green_raw;
	logic                           out_free;

	assign pop       = (state_q == ST_IDLE) && !q_status.empty;
	assign lim_next  = (32'(max_iterations) > ITER_LIMIT) ? CNT_BITS'(ITER_LIMIT)
		: CNT_BITS'(max_iterations);
	assign n_next    = n_q + CNT_BITS'(1);
	assign rr        = prr_q >>> FRAC_BITS;
	assign ii        = pii_q >>> FRAC_BITS;
	assign ri        = pri_q >>> (FRAC_BITS - 1);
	assign escaped   = (rr + ii) >= FOUR;
	assign green_raw = GRAW_BITS'(count_q) * GRAW_BITS'(GREEN_SCALE);
	assign out_free  = !res_valid_q || result_out.ready;

	assign result_out.valid        = res_valid_q;
	assign result_out.escape_count = res_count_q;
	assign result_out.green_level  = res_green_q;
	assign result_out.buffer_index = res_index_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
			res_count_q <= '0;
			res_green_q <= '0;
			res_index_q <= '0;
		end else begin
			if (result_out.ready && state_q != ST_FIN)
				res_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (pop)
						state_q <= (lim_next == '0) ? ST_FIN : ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					if (escaped || n_next == lim_q)
						state_q <= ST_FIN;
					else
						state_q <= ST_MUL;
				end
				ST_FIN: begin
					if (out_free) begin
						res_valid_q <= 1'b1;
						res_count_q <= COUNT_BITS'(count_q);
						res_green_q <= (green_raw > GRAW_BITS'(GREEN_MAX)) ? GREEN_BITS'(GREEN_MAX)
							: GREEN_BITS'(green_raw);
						res_index_q <= idx_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (pop) begin
					cr_q    <= signed'(pop_data[ENTRY_BITS-1 -: COORD_BITS]);
					ci_q    <= signed'(pop_data[ENTRY_BITS-COORD_BITS-1 -: COORD_BITS]);
					zr_q    <= signed'(pop_data[ENTRY_BITS-1 -: COORD_BITS]);
					zi_q    <= signed'(pop_data[ENTRY_BITS-COORD_BITS-1 -: COORD_BITS]);
					idx_q   <= pop_data[INDEX_BITS-1:0];
					n_q     <= '0;
					lim_q   <= lim_next;
					count_q <= '0;
				end
			end
			ST_MUL: begin
				prr_q <= PRODUCT_BITS'(zr_q) * PRODUCT_BITS'(zr_q);
				pii_q <= PRODUCT_BITS'(zi_q) * PRODUCT_BITS'(zi_q);
				pri_q <= PRODUCT_BITS'(zr_q) * PRODUCT_BITS'(zi_q);
			end
			ST_UPD: begin
				if (escaped) begin
					count_q <= n_q;
				end else begin
					zr_q <= sat_coord(rr - ii + PRODUCT_BITS'(cr_q));
					zi_q <= sat_coord(ri + PRODUCT_BITS'(ci_q));
					n_q  <= n_next;
				end
			end
			default: ;
		endcase
	end

endmodule

FILE: rtl/mandelbrot_escape_pixel_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_pixel_top: Mandelbrot escape-time pixel evaluator
// Maps a pixel position to a point of the complex plane, counts the
// iterations of z = z^2 + c until |z|^2 reaches four or the limit is hit,
// and reports the count, a green level and the pixel's linear buffer index.
// ----------------------------------------------------------------------------
// Usage: write the window and limits through the cfg_we/cfg_index/cfg_wdata
// port while the block is idle, then send pixel positions on pixel_in; each
// transfer yields exactly one transfer on result_out, in order.
// A pixel passes the mapping stages of the front and an entry of the queue;
// the iteration engine then loads it, runs a multiply step and an
// add/test/saturate step per iteration tested, and hands the result to the
// output register. Iteration stops at escape or at the limit
// min(max_iterations, ITER_LIMIT). Throughput is set by the engine's
// multiply-then-update loop, one point at a time.
// The front keeps accepting pixels into a two-entry queue while the engine
// works or while a result waits in the output register; when the receiver
// stalls, the result is held and the queue fills before pixel_in.ready drops.
// Reset clears all handshake state and loads the default window; pixel_in is
// not ready while reset is asserted.
// ----------------------------------------------------------------------------
module mandelbrot_escape_pixel_top #(
	parameter int ITER_LIMIT = 1024,
	parameter int COORD_BITS = 32,
	parameter int FRAC_BITS  = 28,
	parameter int POS_BITS   = 12
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [mep_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [COORD_BITS-1:0]               cfg_wdata,
	mep_pixel_if.sink                           pixel_in,
	mep_result_if.source                        result_out
);
	import mep_pkg::*;

	localparam int ENTRY_BITS = 2 * COORD_BITS + INDEX_BITS;

	logic signed [COORD_BITS-1:0] x_start_q;
	logic signed [COORD_BITS-1:0] x_step_q;
	logic signed [COORD_BITS-1:0] y_start_q;
	logic signed [COORD_BITS-1:0] y_step_q;
	logic [WIDTH_BITS-1:0]        image_width_q;
	logic [MAX_ITER_BITS-1:0]     max_iter_q;

	mep_queue_status_t            q_status;
	logic                         push;
	logic                         pop;
	logic [ENTRY_BITS-1:0]        push_data;
	logic [ENTRY_BITS-1:0]        pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_start_q     <= COORD_BITS'(X_START_RESET);
			x_step_q      <= COORD_BITS'(X_STEP_RESET);
			y_start_q     <= COORD_BITS'(Y_START_RESET);
			y_step_q      <= COORD_BITS'(Y_STEP_RESET);
			image_width_q <= WIDTH_BITS'(WIDTH_RESET);
			max_iter_q    <= MAX_ITER_BITS'(MAX_ITER_RESET);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_X_START:        x_start_q     <= signed'(cfg_wdata);
				CFG_X_STEP:         x_step_q      <= signed'(cfg_wdata);
				CFG_Y_START:        y_start_q     <= signed'(cfg_wdata);
				CFG_Y_STEP:         y_step_q      <= signed'(cfg_wdata);
				CFG_IMAGE_WIDTH:    image_width_q <= cfg_wdata[WIDTH_BITS-1:0];
				CFG_MAX_ITERATIONS: max_iter_q    <= cfg_wdata[MAX_ITER_BITS-1:0];
				default: ;
			endcase
		end
	end

	mep_front #(
		.COORD_BITS(COORD_BITS),
		.POS_BITS  (POS_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.x_start    (x_start_q),
		.x_step     (x_step_q),
		.y_start    (y_start_q),
		.y_step     (y_step_q),
		.image_width(image_width_q),
		.pixel_in   (pixel_in),
		.q_status   (q_status),
		.push       (push),
		.push_data  (push_data)
	);

	mep_queue #(
		.WIDTH(ENTRY_BITS),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.pop_data (pop_data),
		.status   (q_status)
	);

	mep_back #(
		.ITER_LIMIT(ITER_LIMIT),
		.COORD_BITS(COORD_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.max_iterations(max_iter_q),
		.q_status      (q_status),
		.pop           (pop),
		.pop_data      (pop_data),
		.result_out    (result_out)
	);

endmodule

FILE: rtl/mep_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mep_checker: port-level assertions for the escape pixel block
// Watches the top-level channels over time and is bound to the top level.
// ----------------------------------------------------------------------------
module mep_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           pixel_ready,
	input logic                           result_valid,
	input logic                           result_ready,
	input logic [mep_pkg::COUNT_BITS-1:0] escape_count,
	input logic [mep_pkg::GREEN_BITS-1:0] green_level,
	input logic [mep_pkg::INDEX_BITS-1:0] buffer_index
);
	import mep_pkg::*;

	logic [COUNT_BITS+1:0] green_expect;

	assign green_expect = (COUNT_BITS + 2)'(escape_count) * (COUNT_BITS + 2)'(GREEN_SCALE);

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=>
			result_valid && $stable({escape_count, green_level, buffer_index}))
		else $error("result changed or dropped while stalled");

	a_green_level: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (green_expect > (COUNT_BITS + 2)'(GREEN_MAX)
			? green_level == GREEN_BITS'(GREEN_MAX)
			: green_level == GREEN_BITS'(green_expect)))
		else $error("green level does not follow escape count");

	a_reset_no_result: assert property (@(posedge clk) !arst_n |-> !result_valid)
		else $error("result offered during reset");

	a_reset_no_intake: assert property (@(posedge clk) !arst_n |-> !pixel_ready)
		else $error("pixel channel ready during reset");

endmodule

bind mandelbrot_escape_pixel_top mep_checker u_mep_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.pixel_ready (pixel_in.ready),
	.result_valid(result_out.valid),
	.result_ready(result_out.ready),
	.escape_count(result_out.escape_count),
	.green_level (result_out.green_level),
	.buffer_index(result_out.buffer_index)
);
